>>> src/dac_pkg.sv
// Package with the shared types, codes and helper functions of the door access controller.
package dac_pkg;

    // Number of digits in one code entry.
    localparam int CODE_LENGTH = 6;
    localparam int CNT_W = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    localparam int CODE_W = 24;
    localparam int TIMER_W = 16;

    // Register indexes on the configuration channel.
    localparam logic CFG_CODE_DIGITS = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    localparam logic [CODE_W-1:0] CODE_RESET = 24'h82CF8B;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd1000;

    // Reciprocal of five for a 16-bit dividend: floor(x * 52429 / 2^18) == x / 5.
    localparam logic [16:0] RECIP_FIVE = 17'd52429;

    typedef enum logic [1:0] {
        CMD_KEY    = 2'd0,
        CMD_CARD   = 2'd1,
        CMD_MOTION = 2'd2,
        CMD_TICK   = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_ALLOWED   = 3'd1,
        ST_WRONG     = 3'd2,
        ST_ENTERING  = 3'd3,
        ST_CARD_FAIL = 3'd4,
        ST_WAIT_CARD = 3'd5
    } access_state_t;

    typedef enum logic [1:0] {
        VD_NONE  = 2'd0,
        VD_WRONG = 2'd1,
        VD_RIGHT = 2'd2
    } verdict_t;

    // Keypad layout, indexed by {row, col}.
    localparam logic [3:0] KEY_TABLE [16] = '{
        4'h1, 4'h2, 4'h3, 4'h4,
        4'h5, 4'h6, 4'h7, 4'h8,
        4'h9, 4'h0, 4'hA, 4'hB,
        4'hC, 4'hD, 4'hE, 4'hF
    };

    // One input event as held in the input register.
    typedef struct packed {
        command_t   command;
        logic [1:0] key_row;
        logic [1:0] key_col;
        logic       card_valid;
        logic       motion_seen;
        logic       pin_level;
    } dac_event_t;

    // Complete controller state.
    typedef struct packed {
        logic [CODE_LENGTH-1:0][3:0] digits;
        logic [CNT_W-1:0]            count;
        verdict_t                    verdict;
        logic                        present;
        access_state_t               door;
        logic                        relay;
        logic [TIMER_W-1:0]          timer_rem;
        logic                        timer_armed;
    } dac_state_t;

    function automatic logic [3:0] key_digit(input logic [1:0] row, input logic [1:0] col);
        return KEY_TABLE[{row, col}];
    endfunction

    // Digit i of the stored code; the first digit sits in the highest used nibble.
    function automatic logic [3:0] code_digit(input logic [CODE_W-1:0] code, input int i);
        int shift;
        shift = 4 * (CODE_LENGTH - 1 - i);
        if (shift >= CODE_W)
        begin
            return 4'h0;
        end
        return code[shift +: 4];
    endfunction

endpackage

>>> src/dac_update.sv
// Next-state logic of the door access controller for one event.
module dac_update (
    input  dac_pkg::dac_event_t          ev,
    input  dac_pkg::dac_state_t          cur,
    input  logic [dac_pkg::CODE_W-1:0]   code_digits,
    input  logic [dac_pkg::TIMER_W-1:0]  timeout_ticks,
    output dac_pkg::dac_state_t          nxt
);

    logic [32:0]                   fifth_prod;
    logic [dac_pkg::TIMER_W-1:0]   half_period;
    logic [dac_pkg::TIMER_W-1:0]   fifth_period;

    assign fifth_prod   = timeout_ticks * dac_pkg::RECIP_FIVE;
    assign fifth_period = {1'b0, fifth_prod[32:18]};
    assign half_period  = {1'b0, timeout_ticks[dac_pkg::TIMER_W-1:1]};

    always_comb
    begin
        logic                          match;
        logic [dac_pkg::TIMER_W-1:0]   period;
        logic [dac_pkg::TIMER_W-1:0]   rem_dec;

        nxt     = cur;
        match   = 1'b1;
        period  = timeout_ticks;
        rem_dec = cur.timer_rem;

        case (ev.command)
            dac_pkg::CMD_KEY:
            begin
                if (cur.count < dac_pkg::CNT_W'(dac_pkg::CODE_LENGTH))
                begin
                    nxt.digits[cur.count[dac_pkg::IDX_W-1:0]] =
                        dac_pkg::key_digit(ev.key_row, ev.key_col);
                    nxt.count = cur.count + 1'b1;
                end
                // A full entry is compared again on every press.
                if (nxt.count >= dac_pkg::CNT_W'(dac_pkg::CODE_LENGTH))
                begin
                    for (int i = 0; i < dac_pkg::CODE_LENGTH; i++)
                    begin
                        if (nxt.digits[i] != dac_pkg::code_digit(code_digits, i))
                        begin
                            match = 1'b0;
                        end
                    end
                    nxt.verdict = match ? dac_pkg::VD_RIGHT : dac_pkg::VD_WRONG;
                end
                case (nxt.verdict)
                    dac_pkg::VD_RIGHT:
                    begin
                        period    = half_period;
                        nxt.door  = dac_pkg::ST_ALLOWED;
                        nxt.relay = 1'b1;
                    end
                    dac_pkg::VD_WRONG:
                    begin
                        period   = fifth_period;
                        nxt.door = dac_pkg::ST_WRONG;
                    end
                    default:
                    begin
                        period   = timeout_ticks;
                        nxt.door = dac_pkg::ST_ENTERING;
                    end
                endcase
                // A period that works out to zero still runs for one tick.
                nxt.timer_rem   = (period == '0) ? dac_pkg::TIMER_W'(1) : period;
                nxt.timer_armed = 1'b1;
            end
            dac_pkg::CMD_CARD:
            begin
                if (cur.present)
                begin
                    nxt.door  = ev.card_valid ? dac_pkg::ST_ALLOWED : dac_pkg::ST_CARD_FAIL;
                    nxt.relay = ev.card_valid;
                end
            end
            dac_pkg::CMD_MOTION:
            begin
                if (ev.motion_seen && ev.pin_level)
                begin
                    nxt.present = 1'b1;
                    nxt.door    = dac_pkg::ST_WAIT_CARD;
                end
                else if (!ev.motion_seen && !ev.pin_level)
                begin
                    nxt.present = 1'b0;
                    nxt.door    = dac_pkg::ST_IDLE;
                    nxt.relay   = 1'b0;
                end
            end
            default:
            begin
                if (cur.timer_armed)
                begin
                    if (cur.timer_rem != '0)
                    begin
                        rem_dec = cur.timer_rem - 1'b1;
                    end
                    nxt.timer_rem = rem_dec;
                    if (rem_dec == '0)
                    begin
                        nxt.timer_armed = 1'b0;
                        if (cur.verdict == dac_pkg::VD_RIGHT)
                        begin
                            if (!cur.present)
                            begin
                                nxt.door  = dac_pkg::ST_IDLE;
                                nxt.relay = 1'b0;
                            end
                        end
                        else if (cur.verdict == dac_pkg::VD_WRONG)
                        begin
                            if (cur.present)
                            begin
                                nxt.door = dac_pkg::ST_WAIT_CARD;
                            end
                            else
                            begin
                                nxt.door  = dac_pkg::ST_IDLE;
                                nxt.relay = 1'b0;
                            end
                        end
                        nxt.count   = '0;
                        nxt.verdict = dac_pkg::VD_NONE;
                    end
                end
            end
        endcase
    end

endmodule

>>> src/door_access_controller.sv
// Top level of the door access controller: stream ports, configuration registers and state.
//
// The door access controller takes one event per input transfer (a keypad press, a card
// verdict, a motion sensor change or a timer tick) and answers every event with exactly one
// output transfer that reports the door state, the relay drive, the number of code digits
// entered and the code verdict after that event. Each event passes through an input register,
// combinational next-state logic and an output register, so the block sustains one transfer
// per clock cycle while m_tready is high. A result waits in the output register until taken,
// while the next event waits in the input register. Key presses fill a six-digit entry that
// is compared against code_digits once full; each press restarts a one-shot timer of
// timeout_ticks, half of it after a correct code or a fifth of it after a wrong code, and
// ticks count the timer down. On expiry the entry and verdict are cleared; after a wrong code
// the door falls back to waiting for a card if someone is present, else to idle, and after a
// correct code to idle if no one is present. Configuration writes are taken at any time but
// are meant to happen only while no event is in flight.
module door_access_controller (
    input  logic        clk,
    input  logic        rst_n,
    // Event input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key_row[1:0], key_col[3:2], card_valid[4],
                                   // motion_seen[5], pin_level[6], zero[7]
    input  logic [1:0]  s_tuser,   // command[1:0]
    // Result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // access_state[2:0], relay_on[3], digits_entered[6:4],
                                   // code_verdict[8:7], zero[15:9]
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    dac_pkg::dac_event_t           in_event_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [15:0]                   out_data_reg;
    logic [15:0]                   out_data_next;
    dac_pkg::dac_state_t           state_reg;
    dac_pkg::dac_state_t           state_next;
    logic [dac_pkg::CODE_W-1:0]    code_digits_reg;
    logic [dac_pkg::TIMER_W-1:0]   timeout_ticks_reg;
    logic                          s_accept;
    logic                          advance;
    logic [7:0]                    count_wide;
    logic [2:0]                    digits_shown;

    // The input register moves on whenever the output register is empty or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    dac_update u_update (
        .ev            (in_event_reg),
        .cur           (state_reg),
        .code_digits   (code_digits_reg),
        .timeout_ticks (timeout_ticks_reg),
        .nxt           (state_next)
    );

    // The count never passes the code length; the report saturates at seven for longer codes.
    assign count_wide   = 8'(state_next.count);
    assign digits_shown = (count_wide > 8'd7) ? 3'd7 : count_wide[2:0];

    assign out_data_next = {7'd0, state_next.verdict, digits_shown, state_next.relay,
                            state_next.door};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            state_reg         <= '0;
            code_digits_reg   <= dac_pkg::CODE_RESET;
            timeout_ticks_reg <= dac_pkg::TIMEOUT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dac_pkg::CFG_CODE_DIGITS:   code_digits_reg   <= cfg_data;
                    dac_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[15:0];
                    default:                    ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_event_reg.command     <= dac_pkg::command_t'(s_tuser);
            in_event_reg.key_row     <= s_tdata[1:0];
            in_event_reg.key_col     <= s_tdata[3:2];
            in_event_reg.card_valid  <= s_tdata[4];
            in_event_reg.motion_seen <= s_tdata[5];
            in_event_reg.pin_level   <= s_tdata[6];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // The entry count never runs past the code length.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.count <= dac_pkg::CNT_W'(dac_pkg::CODE_LENGTH))
        else $error("entry count beyond code length");

    // A verdict exists only for a full entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.verdict != dac_pkg::VD_NONE |->
            state_reg.count == dac_pkg::CNT_W'(dac_pkg::CODE_LENGTH))
        else $error("verdict without a full entry");

    // A running timer always has ticks left.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.timer_armed |-> state_reg.timer_rem != '0)
        else $error("armed timer with nothing remaining");

    // An event that cannot move on stays in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_event_reg))
        else $error("stalled event lost from input register");
`endif

endmodule
